// ----- design/metropolis_spin_flip_sampler_defines.svh -----
// assertion macros shared by the sampler rtl
`ifndef METROPOLIS_SPIN_FLIP_SAMPLER_DEFINES_SVH
`define METROPOLIS_SPIN_FLIP_SAMPLER_DEFINES_SVH

// same-cycle implication, checked on clk_i, off during reset
`define MSFS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk_i, off during reset
`define MSFS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/msfs_pkg.sv -----
// shared types, constants and helpers of the metropolis spin flip sampler
`default_nettype none
package msfs_pkg;

  localparam int unsigned MaxSitesDef = 64;
  localparam logic [63:0] GoldenSeed  = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] Ln2Q64      = 64'hB17217F7D1CF79AB;
  localparam int unsigned LogFracBits = 48;
  localparam logic [5:0]  MantTop     = 6'd52;
  localparam logic [5:0]  MantBits    = 6'd53;
  localparam logic [31:0] CountMax    = 32'hFFFFFFFF;

  localparam logic [1:0] FUNC_START    = 2'd0;
  localparam logic [1:0] FUNC_SET_LOG  = 2'd1;
  localparam logic [1:0] FUNC_PROPOSE  = 2'd2;
  localparam logic [1:0] FUNC_EVALUATE = 2'd3;

  localparam logic REG_SITE_COUNT = 1'b0;
  localparam logic REG_SEED       = 1'b1;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_SEED,
    OP_SPIN_BIT,
    OP_MOD_LOAD,
    OP_MOD_STEP,
    OP_EVAL_R,
    OP_EVAL_DRAW,
    OP_NORM_STEP,
    OP_SQ_START,
    OP_SQ_TAKE,
    OP_LN_START,
    OP_LN_CMP,
    OP_FINISH
  } dp_op_e;

  typedef struct packed {
    dp_op_e     op;
    logic [5:0] idx;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       pend_valid;
    logic       take;
    logic       norm_done;
    logic       mul_done;
    logic       out_free;
    logic [5:0] last_idx;
  } dp_sts_t;

  function automatic logic [63:0] xorshift64(input logic [63:0] x);
    logic [63:0] t;
    t = x ^ (x << 13);
    t = t ^ (t >> 7);
    t = t ^ (t << 17);
    return t;
  endfunction

endpackage
`default_nettype wire

// ----- design/msfs_if.sv -----
// valid/ready channel interfaces for items and results
`default_nettype none
interface msfs_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic signed [31:0] log_amp_value;

  modport source (output valid, output func, output log_amp_value, input ready);
  modport sink (input valid, input func, input log_amp_value, output ready);
endinterface

interface msfs_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] spins;
  logic [5:0]  site;
  logic        accepted;
  logic [31:0] proposed_count;
  logic [31:0] accepted_count;

  modport source (output valid, output spins, output site, output accepted,
                  output proposed_count, output accepted_count, input ready);
  modport sink (input valid, input spins, input site, input accepted,
                input proposed_count, input accepted_count, output ready);
endinterface
`default_nettype wire

// ----- design/msfs_mul.sv -----
// sequential 64x64 multiplier built from four 32x32 partial products
`default_nettype none
module msfs_mul
  import msfs_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [63:0]  a_i,
  input  wire logic [63:0]  b_i,
  output logic              done_o,
  output logic [127:0]      prod_o
);

  logic [63:0]  a_q, b_q;
  logic [63:0]  p_q;
  logic [1:0]   sh_q;
  logic [127:0] acc_q;
  logic [2:0]   cnt_q;
  logic         busy_q, pv_q, done_q;
  logic [31:0]  a_half, b_half;
  logic [127:0] p_shift;

  assign a_half = cnt_q[1] ? a_q[63:32] : a_q[31:0];
  assign b_half = cnt_q[0] ? b_q[63:32] : b_q[31:0];

  always_comb begin
    case (sh_q)
      2'd0:    p_shift = {64'd0, p_q};
      2'd1:    p_shift = {32'd0, p_q, 32'd0};
      default: p_shift = {p_q, 64'd0};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pv_q   <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 3'd0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        pv_q   <= 1'b0;
        cnt_q  <= 3'd0;
      end else if (busy_q) begin
        pv_q  <= !cnt_q[2];
        cnt_q <= cnt_q + 3'd1;
        if (cnt_q[2]) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= 128'd0;
    end else if (busy_q) begin
      if (!cnt_q[2]) begin
        p_q  <= a_half * b_half;
        sh_q <= 2'({1'b0, cnt_q[1]} + {1'b0, cnt_q[0]});
      end
      if (pv_q) acc_q <= acc_q + p_shift;
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule
`default_nettype wire

// ----- design/msfs_ctrl.sv -----
// sequencing state machine of the sampler
`default_nettype none
module msfs_ctrl
  import msfs_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire dp_sts_t sts_i,
  output dp_cmd_t      cmd_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DISP = 4'd1;
  localparam logic [3:0] S_SPIN = 4'd2;
  localparam logic [3:0] S_MOD  = 4'd3;
  localparam logic [3:0] S_EVAL = 4'd4;
  localparam logic [3:0] S_DRAW = 4'd5;
  localparam logic [3:0] S_NORM = 4'd6;
  localparam logic [3:0] S_SQ   = 4'd7;
  localparam logic [3:0] S_SQW  = 4'd8;
  localparam logic [3:0] S_LN   = 4'd9;
  localparam logic [3:0] S_LNW  = 4'd10;
  localparam logic [3:0] S_FIN  = 4'd11;

  localparam logic [5:0] SqLast = 6'(LogFracBits - 1);

  logic [3:0] state_q, state_d;
  logic [5:0] cnt_q, cnt_d;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    in_ready_o = 1'b0;
    cmd_o.op   = OP_NONE;
    cmd_o.idx  = cnt_q;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LATCH;
          state_d  = S_DISP;
        end
      end
      S_DISP: begin
        cnt_d = 6'd0;
        unique case (sts_i.func)
          FUNC_START: begin
            cmd_o.op = OP_SEED;
            state_d  = S_SPIN;
          end
          FUNC_SET_LOG: state_d = S_FIN;
          FUNC_PROPOSE: begin
            cmd_o.op = OP_MOD_LOAD;
            state_d  = S_MOD;
          end
          FUNC_EVALUATE: state_d = S_EVAL;
          default: state_d = S_FIN;
        endcase
      end
      S_SPIN: begin
        cmd_o.op = OP_SPIN_BIT;
        cnt_d    = cnt_q + 6'd1;
        if (cnt_q == sts_i.last_idx) state_d = S_FIN;
      end
      S_MOD: begin
        cmd_o.op = OP_MOD_STEP;
        cnt_d    = cnt_q + 6'd1;
        if (&cnt_q) state_d = S_FIN;
      end
      S_EVAL: begin
        cmd_o.op = OP_EVAL_R;
        state_d  = sts_i.pend_valid ? S_DRAW : S_FIN;
      end
      S_DRAW: begin
        // a non-negative ratio accepts without a draw
        if (sts_i.take) begin
          state_d = S_FIN;
        end else begin
          cmd_o.op = OP_EVAL_DRAW;
          state_d  = S_NORM;
        end
      end
      S_NORM: begin
        if (sts_i.take) begin
          state_d = S_FIN;
        end else if (sts_i.norm_done) begin
          cnt_d   = 6'd0;
          state_d = S_SQ;
        end else begin
          cmd_o.op = OP_NORM_STEP;
        end
      end
      S_SQ: begin
        cmd_o.op = OP_SQ_START;
        state_d  = S_SQW;
      end
      S_SQW: begin
        if (sts_i.mul_done) begin
          cmd_o.op = OP_SQ_TAKE;
          cnt_d    = cnt_q + 6'd1;
          state_d  = (cnt_q == SqLast) ? S_LN : S_SQ;
        end
      end
      S_LN: begin
        cmd_o.op = OP_LN_START;
        state_d  = S_LNW;
      end
      S_LNW: begin
        if (sts_i.mul_done) begin
          cmd_o.op = OP_LN_CMP;
          state_d  = S_FIN;
        end
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.op = OP_FINISH;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= 6'd0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule
`default_nettype wire

// ----- design/msfs_dp.sv -----
// sampler datapath: spins, generator, divider, log unit and result register
`default_nettype none
module msfs_dp
  import msfs_pkg::*;
#(
  parameter int unsigned MaxSites = MaxSitesDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_index_i,
  input  wire logic [63:0]        cfg_wdata_i,
  input  wire logic [1:0]         in_func_i,
  input  wire logic signed [31:0] in_value_i,
  input  wire dp_cmd_t            cmd_i,
  output dp_sts_t                 sts_o,
  input  wire logic               out_ready_i,
  output logic                    out_valid_o,
  output logic [63:0]             out_spins_o,
  output logic [5:0]              out_site_o,
  output logic                    out_accepted_o,
  output logic [31:0]             out_proposed_o,
  output logic [31:0]             out_taken_o
);

  localparam logic [6:0] MaxSitesW = 7'(MaxSites);

  logic [6:0]         site_count_q;
  logic [63:0]        seed_q;
  logic [1:0]         func_q;
  logic signed [31:0] val_q, cur_q;
  logic [63:0]        spin_q, rng_q, div_q, m_q;
  logic [5:0]         site_q, e_q;
  logic               pend_q, take_q;
  logic [31:0]        tried_q, taken_q;
  logic [6:0]         rem_q;
  logic [33:0]        negr_q;
  logic [47:0]        frac_q;
  logic               out_valid_q;

  logic [63:0]  rng_next;
  logic [6:0]   sites;
  logic [6:0]   rem_sh, rem_next;
  logic [32:0]  diff;
  logic [32:0]  diff_neg;
  logic [53:0]  neg_log;
  logic         mul_start, mul_done;
  logic [63:0]  mul_a, mul_b;
  logic [127:0] prod;
  logic [32:0]  ln_c;
  logic         take_e;
  logic [31:0]  tried_inc, taken_inc;
  logic [63:0]  site_bit, rem_bit;

  assign rng_next = xorshift64(rng_q);

  always_comb begin
    if (site_count_q == 7'd0) sites = 7'd1;
    else if (site_count_q > MaxSitesW) sites = MaxSitesW;
    else sites = site_count_q;
  end

  // restoring remainder, one dividend bit per step
  assign rem_sh   = {rem_q[5:0], div_q[63]};
  assign rem_next = (rem_sh >= sites) ? rem_sh - sites : rem_sh;

  assign diff     = {val_q[31], val_q} - {cur_q[31], cur_q};
  assign diff_neg = 33'd0 - diff;

  // distance of log2(x) below 53, in 6.48 fixed point
  assign neg_log = {MantBits, 48'd0} - {e_q, frac_q};

  assign mul_start = (cmd_i.op == OP_SQ_START) || (cmd_i.op == OP_LN_START);
  assign mul_a     = (cmd_i.op == OP_SQ_START) ? m_q : {10'd0, neg_log};
  assign mul_b     = (cmd_i.op == OP_SQ_START) ? m_q : Ln2Q64;

  msfs_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (prod)
  );

  // ceiling of the product's top 32 bits
  assign ln_c = {1'b0, prod[127:96]} + {32'd0, |prod[95:0]};

  assign take_e    = pend_q && take_q;
  assign tried_inc = (tried_q == CountMax) ? tried_q : tried_q + 32'd1;
  assign taken_inc = (taken_q == CountMax) ? taken_q : taken_q + 32'd1;
  assign site_bit  = 64'd1 << site_q;
  assign rem_bit   = 64'd1 << rem_q[5:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      site_count_q <= 7'(MaxSites);
      seed_q       <= 64'd0;
      spin_q       <= 64'd0;
      cur_q        <= 32'sd0;
      rng_q        <= GoldenSeed;
      site_q       <= 6'd0;
      pend_q       <= 1'b0;
      tried_q      <= 32'd0;
      taken_q      <= 32'd0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_SITE_COUNT: site_count_q <= cfg_wdata_i[6:0];
          REG_SEED:       seed_q       <= cfg_wdata_i;
          default:        seed_q       <= seed_q;
        endcase
      end
      if (out_ready_i) out_valid_q <= 1'b0;
      case (cmd_i.op) inside
        OP_SEED: begin
          rng_q   <= (seed_q != 64'd0) ? seed_q : GoldenSeed;
          spin_q  <= 64'd0;
          cur_q   <= 32'sd0;
          site_q  <= 6'd0;
          pend_q  <= 1'b0;
          tried_q <= 32'd0;
          taken_q <= 32'd0;
        end
        OP_SPIN_BIT: begin
          rng_q             <= rng_next;
          spin_q[cmd_i.idx] <= rng_next[0];
        end
        OP_MOD_LOAD, OP_EVAL_DRAW: rng_q <= rng_next;
        OP_FINISH: begin
          out_valid_q <= 1'b1;
          case (func_q)
            FUNC_SET_LOG: cur_q <= val_q;
            FUNC_PROPOSE: begin
              site_q <= rem_q[5:0];
              pend_q <= 1'b1;
            end
            FUNC_EVALUATE: begin
              if (pend_q) begin
                tried_q <= tried_inc;
                pend_q  <= 1'b0;
              end
              if (take_e) begin
                taken_q <= taken_inc;
                spin_q  <= spin_q ^ site_bit;
                cur_q   <= val_q;
              end
            end
            default: pend_q <= pend_q;
          endcase
        end
        default: pend_q <= pend_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LATCH: begin
        func_q <= in_func_i;
        val_q  <= in_value_i;
      end
      OP_MOD_LOAD: begin
        div_q <= rng_next;
        rem_q <= 7'd0;
      end
      OP_MOD_STEP: begin
        div_q <= {div_q[62:0], 1'b0};
        rem_q <= rem_next;
      end
      OP_EVAL_R: begin
        take_q <= !diff[32];
        negr_q <= {diff_neg, 1'b0};
      end
      OP_EVAL_DRAW: begin
        m_q    <= {rng_next[63:11], 11'd0};
        e_q    <= MantTop;
        take_q <= (rng_next[63:11] == 53'd0);
      end
      OP_NORM_STEP: begin
        m_q <= {m_q[62:0], 1'b0};
        e_q <= e_q - 6'd1;
      end
      OP_SQ_TAKE: begin
        frac_q <= {frac_q[46:0], prod[127]};
        m_q    <= prod[127] ? prod[127:64] : prod[126:63];
      end
      OP_LN_CMP: take_q <= ({1'b0, ln_c} > negr_q);
      OP_FINISH: begin
        out_site_o     <= site_q;
        out_accepted_o <= 1'b0;
        out_proposed_o <= tried_q;
        out_taken_o    <= taken_q;
        out_spins_o    <= spin_q;
        case (func_q)
          FUNC_START: begin
            out_proposed_o <= 32'd0;
            out_taken_o    <= 32'd0;
          end
          FUNC_PROPOSE: begin
            out_site_o  <= rem_q[5:0];
            out_spins_o <= spin_q ^ rem_bit;
          end
          FUNC_EVALUATE: begin
            if (pend_q) out_proposed_o <= tried_inc;
            if (take_e) begin
              out_accepted_o <= 1'b1;
              out_taken_o    <= taken_inc;
              out_spins_o    <= spin_q ^ site_bit;
            end
          end
          default: out_accepted_o <= 1'b0;
        endcase
      end
      default: take_q <= take_q;
    endcase
  end

  assign sts_o.func       = func_q;
  assign sts_o.pend_valid = pend_q;
  assign sts_o.take       = take_q;
  assign sts_o.norm_done  = m_q[63];
  assign sts_o.mul_done   = mul_done;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;
  assign sts_o.last_idx   = 6'(sites - 7'd1);

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

// ----- design/metropolis_spin_flip_sampler.sv -----
// top level of the metropolis spin flip sampler
//
//  channel  dir  handshake      payload
//  in_i     in   valid/ready    func, log_amp_value
//  out_o    out  valid/ready    spins, site, accepted, proposed_count, accepted_count
//  cfg      in   cfg_we_i       cfg_index_i, cfg_wdata_i (0 site_count, 1 seed)
//
// one transaction at a time; in_i.ready is high only while the sequencer is idle
// start makes one generator draw per site; set log only latches the value and finishes
// propose: one draw, reduced by the one-bit-per-cycle remainder over the 64-bit draw
// evaluate: the long case is normalization (up to 52 shifts)
//   plus 48 squarings and one ln2 product on the four-step 32x32 multiplier
// a result held in the output register stalls only the finish of the next one
// reset is asynchronous; no clearing pass follows it
`default_nettype none
`include "metropolis_spin_flip_sampler_defines.svh"
module metropolis_spin_flip_sampler
  import msfs_pkg::*;
#(
  parameter int unsigned MaxSites = MaxSitesDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_index_i,
  input  wire logic [63:0] cfg_wdata_i,
  msfs_in_if.sink          in_i,
  msfs_out_if.source       out_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  msfs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  msfs_dp #(
    .MaxSites (MaxSites)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_func_i      (in_i.func),
    .in_value_i     (in_i.log_amp_value),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_ready_i    (out_o.ready),
    .out_valid_o    (out_o.valid),
    .out_spins_o    (out_o.spins),
    .out_site_o     (out_o.site),
    .out_accepted_o (out_o.accepted),
    .out_proposed_o (out_o.proposed_count),
    .out_taken_o    (out_o.accepted_count)
  );

  `MSFS_ASSERT_SAME(a_count_order, out_o.valid,
                    out_o.accepted_count <= out_o.proposed_count,
                    "accepted count above proposed count")
  `MSFS_ASSERT_SAME(a_accept_counted, out_o.valid && out_o.accepted,
                    out_o.proposed_count != 32'd0 && out_o.accepted_count != 32'd0,
                    "accept without counted proposal")
  `MSFS_ASSERT_NEXT(a_one_item, in_i.valid && in_i.ready, !in_i.ready,
                    "second transaction taken while busy")

endmodule
`default_nettype wire

// ----- test/metropolis_spin_flip_sampler_tb.sv -----
// testbench of the metropolis spin flip sampler: directed table, random walks, predictor check
`timescale 1ns / 100ps
module metropolis_spin_flip_sampler_tb;
  import msfs_pkg::*;

  localparam int unsigned CycleLimit = 3000000;
  localparam int unsigned DrainCycles = 400;

  typedef struct {
    logic [63:0] spins;
    logic [5:0]  site;
    logic        accepted;
    logic [31:0] proposed_count;
    logic [31:0] accepted_count;
  } sample_t;

  typedef struct {
    logic [1:0]  func;
    logic [31:0] value;
    bit          typed;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_index_i = REG_SITE_COUNT;
  logic [63:0] cfg_wdata_i = '0;

  msfs_in_if  in_if ();
  msfs_out_if out_if ();

  metropolis_spin_flip_sampler dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // sampler model state
  logic [6:0]         sites_reg;
  logic [63:0]        seed_reg;
  logic [63:0]        spin_word;
  logic signed [31:0] cur_log;
  logic [63:0]        gen_word;
  logic [5:0]         pend_site;
  logic               pend_ok;
  logic [31:0]        tried_cnt;
  logic [31:0]        taken_cnt;

  sample_t     pending_samples[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned n_items = 0;
  int unsigned n_evals = 0;
  int unsigned n_takes = 0;
  int unsigned n_starts = 0;
  bit          quiet = 1'b0;

  function automatic logic [63:0] next_draw();
    logic [63:0] x;
    x = gen_word;
    x = x ^ (x << 13);
    x = x ^ (x >> 7);
    x = x ^ (x << 17);
    gen_word = x;
    return x;
  endfunction

  function automatic int unsigned active_sites();
    if (sites_reg == 0) return 1;
    if (sites_reg > 64) return 64;
    return sites_reg;
  endfunction

  // ceil of -ln(x / 2^53) in Q16.16 via bit-serial log2
  function automatic logic [63:0] neg_ln_q16(input logic [63:0] x);
    int          e;
    logic [63:0] m;
    logic [63:0] frac;
    logic [63:0] span;
    logic [127:0] p;
    e = 52;
    while (e > 0 && !x[e]) e--;
    m = x << (63 - e);
    frac = '0;
    for (int i = 0; i < LogFracBits; i++) begin
      p = {64'd0, m} * {64'd0, m};
      frac = frac << 1;
      if (p[127]) begin
        frac[0] = 1'b1;
        m = p[127:64];
      end else begin
        m = p[126:63];
      end
    end
    span = (64'd53 << LogFracBits) - ((64'(e) << LogFracBits) | frac);
    p = {64'd0, span} * {64'd0, Ln2Q64};
    return 64'(p[127:96]) + ((p[95:0] != 0) ? 64'd1 : 64'd0);
  endfunction

  function automatic sample_t step_sampler(input logic [1:0] f, input logic [31:0] v);
    sample_t     s;
    logic [63:0] shown;
    logic [63:0] x;
    longint      r;
    bit          take;
    s.accepted = 1'b0;
    case (f)
      FUNC_START: begin
        gen_word = (seed_reg != 0) ? seed_reg : GoldenSeed;
        spin_word = '0;
        for (int i = 0; i < active_sites(); i++) begin
          x = next_draw();
          spin_word[i] = x[0];
        end
        cur_log = '0;
        pend_site = '0;
        pend_ok = 1'b0;
        tried_cnt = '0;
        taken_cnt = '0;
        shown = spin_word;
        n_starts++;
      end
      FUNC_SET_LOG: begin
        cur_log = v;
        shown = spin_word;
      end
      FUNC_PROPOSE: begin
        pend_site = 6'(next_draw() % active_sites());
        pend_ok = 1'b1;
        shown = spin_word ^ (64'd1 << pend_site);
      end
      default: begin
        if (pend_ok) begin
          r = 2 * (longint'($signed(v)) - longint'(cur_log));
          if (r >= 0) begin
            take = 1'b1;
          end else begin
            x = next_draw() >> 11;
            take = (x == 0) || (neg_ln_q16(x) > 64'(-r));
          end
          n_evals++;
          if (tried_cnt != CountMax) tried_cnt++;
          if (take) begin
            if (taken_cnt != CountMax) taken_cnt++;
            spin_word[pend_site] = ~spin_word[pend_site];
            cur_log = v;
            s.accepted = 1'b1;
            n_takes++;
          end
          pend_ok = 1'b0;
        end
        shown = spin_word;
      end
    endcase
    s.spins = shown;
    s.site = pend_site;
    s.proposed_count = tried_cnt;
    s.accepted_count = taken_cnt;
    return s;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic send_item(input logic [1:0] f, input logic [31:0] v, input bit typed);
    int unsigned gap;
    sample_t     s;
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.func <= f;
    in_if.log_amp_value <= v;
    do @(posedge clk_i); while (!in_if.ready);
    s = step_sampler(f, v);
    // rows right after reset are known without the model
    if (typed) s = '{spins: '0, site: '0, accepted: 1'b0, proposed_count: '0,
                     accepted_count: '0};
    pending_samples.push_back(s);
    n_items++;
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [63:0] data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (idx == REG_SITE_COUNT) sites_reg = data[6:0];
    else seed_reg = data;
  endtask

  // result side: check every transaction, stall at random
  int unsigned stall_left = 0;
  always @(posedge clk_i) begin
    sample_t e;
    if (out_if.valid && out_if.ready) begin
      if (pending_samples.size() == 0) begin
        $error("result with nothing expected: spins %h", out_if.spins);
        errors++;
      end else begin
        e = pending_samples.pop_front();
        if (out_if.spins !== e.spins) begin
          $error("spins: expected %h, got %h", e.spins, out_if.spins);
          errors++;
        end
        if (out_if.site !== e.site) begin
          $error("site: expected %0d, got %0d", e.site, out_if.site);
          errors++;
        end
        if (out_if.accepted !== e.accepted) begin
          $error("accepted: expected %0d, got %0d", e.accepted, out_if.accepted);
          errors++;
        end
        if (out_if.proposed_count !== e.proposed_count) begin
          $error("proposed_count: expected %0d, got %0d", e.proposed_count,
                 out_if.proposed_count);
          errors++;
        end
        if (out_if.accepted_count !== e.accepted_count) begin
          $error("accepted_count: expected %0d, got %0d", e.accepted_count,
                 out_if.accepted_count);
          errors++;
        end
      end
    end
    if (!rst_ni || quiet) begin
      out_if.ready <= 1'b1;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_if.ready <= 1'b0;
      stall_left--;
    end else begin
      out_if.ready <= 1'b1;
      if ($urandom_range(0, 99) < 20)
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 80)
                                                 : $urandom_range(1, 3);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  stim_row_t directed[17] = '{
    '{FUNC_EVALUATE, 32'h0000_0000, 1'b1},  // evaluate with nothing proposed
    '{FUNC_SET_LOG,  32'h7FFF_FFFF, 1'b1},
    '{FUNC_SET_LOG,  32'h8000_0000, 1'b1},
    '{FUNC_START,    32'h0000_0000, 1'b0},
    '{FUNC_PROPOSE,  32'h0000_0000, 1'b0},
    '{FUNC_EVALUATE, 32'h7FFF_FFFF, 1'b0},  // uphill move always taken
    '{FUNC_PROPOSE,  32'hFFFF_FFFF, 1'b0},
    '{FUNC_EVALUATE, 32'h8000_0000, 1'b0},  // steepest downhill
    '{FUNC_PROPOSE,  32'h0000_0000, 1'b0},
    '{FUNC_PROPOSE,  32'h0000_0000, 1'b0},  // replaces the pending site
    '{FUNC_EVALUATE, 32'h7FFF_FFFF, 1'b0},
    '{FUNC_EVALUATE, 32'hFFFF_FFFF, 1'b0},  // no proposal left
    '{FUNC_SET_LOG,  32'h0000_0000, 1'b0},
    '{FUNC_PROPOSE,  32'h0000_0000, 1'b0},
    '{FUNC_EVALUATE, 32'hFFFF_0000, 1'b0},
    '{FUNC_PROPOSE,  32'h0000_0000, 1'b0},
    '{FUNC_EVALUATE, 32'hFFFF_FFFE, 1'b0}
  };

  logic [6:0]  phase_sites[7] = '{7'd1, 7'd0, 7'd127, 7'd64, 7'd65, 7'd7, 7'd33};
  logic [63:0] phase_seed[7];

  initial begin
    logic [31:0] delta;
    int unsigned pick;
    in_if.valid = 1'b0;
    in_if.func = FUNC_START;
    in_if.log_amp_value = '0;
    sites_reg = 7'd64;
    seed_reg = '0;
    spin_word = '0;
    cur_log = '0;
    gen_word = GoldenSeed;
    pend_site = '0;
    pend_ok = 1'b0;
    tried_cnt = '0;
    taken_cnt = '0;
    phase_seed = '{64'd0, {$urandom, $urandom}, 64'hFFFF_FFFF_FFFF_FFFF,
                   {$urandom, $urandom}, 64'd1, {$urandom, $urandom}, 64'd0};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) send_item(directed[i].func, directed[i].value, directed[i].typed);

    for (int ph = 0; ph < 7; ph++) begin
      wait_idle();
      quiet = (ph == 3);
      write_reg(REG_SITE_COUNT, 64'(phase_sites[ph]));
      write_reg(REG_SEED, phase_seed[ph]);
      send_item(FUNC_START, $urandom, 1'b0);
      while (n_items < 17 + (ph + 1) * 276) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          // proposal followed by a value that is mostly near the current one
          send_item(FUNC_PROPOSE, $urandom, 1'b0);
          delta = ($urandom_range(0, 9) == 0) ? $urandom
                                              : 32'($signed($urandom_range(0, 6 << 16))
                                                    - (3 << 16));
          send_item(FUNC_EVALUATE, cur_log + delta, 1'b0);
        end else if (pick < 78) begin
          send_item(FUNC_SET_LOG, ($urandom_range(0, 1) != 0) ? $urandom
                                  : 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16)),
                    1'b0);
        end else if (pick < 81) begin
          send_item(FUNC_START, $urandom, 1'b0);
        end else if (pick < 90) begin
          send_item(($urandom_range(0, 1) != 0) ? FUNC_EVALUATE : FUNC_PROPOSE,
                    cur_log - 32'($urandom_range(0, 1 << 16)), 1'b0);
        end else begin
          send_item(2'($urandom), $urandom, 1'b0);
        end
      end
      quiet = 1'b0;
    end

    wait_idle();
    $display("covered %0d items, %0d starts, %0d evaluations with %0d taken,",
             n_items, n_starts, n_evals, n_takes);
    $display("over seven site count and seed settings with random gaps and stalls");
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+design
design/msfs_pkg.sv
design/msfs_if.sv
design/msfs_mul.sv
design/msfs_ctrl.sv
design/msfs_dp.sv
design/metropolis_spin_flip_sampler.sv
test/metropolis_spin_flip_sampler_tb.sv
